/* sv/handle_resource_table_unit_defines.svh */
// Assertion macros shared by the handle resource table RTL.
`ifndef HANDLE_RESOURCE_TABLE_UNIT_DEFINES_SVH
`define HANDLE_RESOURCE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

/* sv/hrt_pkg.sv */
package hrt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam int HANDLE_W    = 32;
    localparam int KEY_W       = 9;
    localparam int STATUS_W    = 2;
    localparam int OUT_IDX_W   = 7;
    localparam int DEV_W       = 31;

    localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [HANDLE_W-1:0] H_PASS_MAX = 32'd31;
    localparam logic [HANDLE_W-1:0] H_SPEC_A   = 32'h0000_010A;
    localparam logic [HANDLE_W-1:0] H_SPEC_B   = 32'h0000_010B;
    localparam logic [HANDLE_W-1:0] H_RANGE_LO = 32'h0000_0120;
    localparam logic [HANDLE_W-1:0] H_RANGE_HI = 32'h0000_012F;

    localparam logic [DEV_W-1:0] D_SPEC_A   = 31'h4000_000A;
    localparam logic [DEV_W-1:0] D_SPEC_B   = 31'h4000_000B;
    localparam logic [DEV_W-1:0] D_RANGE_LO = 31'h4000_0110;

    typedef struct packed {
        logic             ok;
        logic [DEV_W-1:0] dev;
    } xlate_t;

    // Map a software handle to its device handle; ok drops for unknown handles.
    function automatic xlate_t translate(input logic [HANDLE_W-1:0] h);
        xlate_t r;
        r.ok  = 1'b1;
        r.dev = '0;
        if (h <= H_PASS_MAX) begin
            r.dev = DEV_W'(h);
        end else if (h == H_SPEC_A) begin
            r.dev = D_SPEC_A;
        end else if (h == H_SPEC_B) begin
            r.dev = D_SPEC_B;
        end else if (h >= H_RANGE_LO && h <= H_RANGE_HI) begin
            r.dev = D_RANGE_LO + DEV_W'(h[3:0]);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

/* sv/handle_resource_table_unit.sv */
// The scan walks up to F filled entries (F = 0..128) between the start beat and the done strobe.
// A new handle is accepted only while idle; the key memory scan reads one entry per cycle.
// A bad handle skips the scan.
// Reset (rst_n low, asynchronous) empties the table and drops busy and done.
// The receiver cannot stall: every result shows for exactly one cycle under done.
`include "handle_resource_table_unit_defines.svh"

module handle_resource_table_unit
    import hrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [HANDLE_W-1:0]  handle,
    output logic                 done,
    output logic [STATUS_W-1:0]  status,
    output logic [OUT_IDX_W-1:0] entry_index,
    output logic [DEV_W-1:0]     device_handle
);

    // Two-state sequencer: wait for a beat, then walk the filled keys.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Stored keys live in a synchronous memory with a registered read port.
    // Entries at or above the fill count are never compared, so no clear is needed.
    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    logic state_reg, state_next;

    // Per-item working copy: key, translation and whether it translated at all.
    xlate_t           xl;
    logic [KEY_W-1:0] key_reg;
    logic [DEV_W-1:0] dev_reg;
    logic             ok_reg;

    // Scan bookkeeping: issue counter runs one ahead of the compare.
    logic [COUNT_W-1:0] issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pidx_reg;
    logic [COUNT_W-1:0] fill_reg, fill_next;

    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_next;
    logic [OUT_IDX_W-1:0] index_next;
    logic [DEV_W-1:0]     dev_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [OUT_IDX_W-1:0] index_reg;
    logic [DEV_W-1:0]     devout_reg;

    logic accept;
    logic hit;
    logic scan_end;

    assign accept   = start && (state_reg == S_IDLE);
    assign xl       = translate(handle);
    assign hit      = pend_reg && (rd_data_reg == key_reg);
    // Unknown handles were never stored, so they skip the walk entirely.
    assign scan_end = !ok_reg || (issue_reg >= fill_reg);
    assign rd_addr  = issue_reg[IDX_W-1:0];
    assign mem_we   = (state_reg == S_SCAN) && !hit && scan_end && ok_reg
                      && (fill_reg < COUNT_W'(TABLE_DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        issue_next  = issue_reg;
        pend_next   = 1'b0;
        fill_next   = fill_reg;
        done_next   = 1'b0;
        status_next = ST_FOUND;
        index_next  = '0;
        dev_next    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    issue_next = '0;
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    // Match on the entry read last cycle: report it, table unchanged.
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_FOUND;
                    index_next  = OUT_IDX_W'(pidx_reg);
                    dev_next    = dev_reg;
                end
                else if (!scan_end)
                begin
                    // Issue the next read and hold its index for the compare.
                    issue_next = issue_reg + COUNT_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    // Miss: classify, and append the key when there is room.
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (!ok_reg)
                    begin
                        status_next = ST_BAD;
                    end
                    else if (!mem_we)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_CREATED;
                        index_next  = OUT_IDX_W'(fill_reg);
                        dev_next    = dev_reg;
                        fill_next   = fill_reg + COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= handle[KEY_W-1:0];
            dev_reg <= xl.dev;
            ok_reg  <= xl.ok;
        end
        if (pend_next)
        begin
            pidx_reg <= rd_addr;
        end
        status_reg <= status_next;
        index_reg  <= index_next;
        devout_reg <= dev_next;
    end

    // Key memory: one write port at the fill point, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[fill_reg[IDX_W-1:0]] <= key_reg;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign entry_index   = index_reg;
    assign device_handle = devout_reg;

    `HRT_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= COUNT_W'(TABLE_DEPTH))
    `HRT_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE)
    `HRT_ASSERT_NOW(a_created_fill, done_reg && (status_reg == ST_CREATED), fill_reg == COUNT_W'(index_reg) + COUNT_W'(1))
    `HRT_ASSERT_NEXT(a_hit_found, (state_reg == S_SCAN) && hit, done_reg && (status_reg == ST_FOUND))
    `HRT_ASSERT_NEXT(a_accept_busy, accept, busy && !done_reg)

endmodule
